// ===== hdl/usan_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// usan_pkg: shared types and helpers of the UTF-8 stream sanitizer
// Transfer structs, the job record passed from front to back end, and the
// code point range check.
// ---------------------------------------------------------------------------
package usan_pkg;

	// Default depth of the job queue between front and back end.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Lead byte lengths.
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// One input transfer.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} usan_in_t;

	// One result transfer.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_end;
	} usan_out_t;

	// Everything one input byte produces, handed to the back end as one record.
	typedef struct packed {
		logic [3:0][7:0] bytes;    // bytes to emit, first in element 0
		logic [1:0]      last_idx; // number of results minus one
		logic            marker;   // bare end marker, no byte carried
		logic            last;     // input byte ended the string
	} usan_job_t;

	// Push side of the job queue.
	typedef struct packed {
		logic      push;
		usan_job_t job;
	} usan_push_t;

	// Head of the job queue as seen by the back end.
	typedef struct packed {
		logic      ready;
		usan_job_t job;
	} usan_head_t;

	// True when a decoded code point is legal for its sequence length.
	function automatic logic point_ok(input logic [2:0] len, input logic [20:0] cp);
		logic ok;
		ok = 1'b0;
		unique case (len)
			LEN_TWO:   ok = (cp >= 21'h80) && (cp <= 21'h7FF);
			LEN_THREE: ok = ((cp >= 21'h800) && (cp <= 21'hD7FF))
				|| ((cp >= 21'hE000) && (cp <= 21'hFFFF));
			LEN_FOUR:  ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
			default:   ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/usan_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// usan_front: byte classifier and sequence tracker
// Accepts one byte per cycle unless the job queue is full, tracks the pending
// multi-byte sequence and pushes one job per byte that yields any result.
// ---------------------------------------------------------------------------
module usan_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   feed_valid,
	input  usan_pkg::usan_in_t    feed_item,
	input  wire                   queue_full,
	output logic                  feed_stall,
	output usan_pkg::usan_push_t  job_push
);
	import usan_pkg::*;

	logic [7:0]  held_q [3];
	logic [2:0]  exp_len_q;
	logic [1:0]  held_count_q;
	logic [20:0] point_q;

	logic        accept;
	logic [7:0]  b;
	logic        pending;
	logic        is_cont;
	logic        consumed;
	logic        complete;
	logic [20:0] point_shift;
	logic [2:0]  exp_len_n;
	logic [1:0]  held_count_n;
	logic [20:0] point_n;
	logic        held_wr;
	logic [1:0]  held_wr_idx;
	logic        emit;
	usan_job_t   job;

	assign feed_stall = queue_full;
	assign accept     = feed_valid && !feed_stall;
	assign b          = feed_item.data_byte;

	// Classify the byte against the pending sequence and build the job.
	always_comb begin
		pending      = (exp_len_q != LEN_NONE);
		is_cont      = (b[7:6] == 2'b10);
		consumed     = pending && is_cont;
		point_shift  = {point_q[14:0], b[5:0]};
		complete     = consumed && (({1'b0, held_count_q} + 3'd1) >= exp_len_q);
		exp_len_n    = exp_len_q;
		held_count_n = held_count_q;
		point_n      = point_q;
		held_wr      = 1'b0;
		held_wr_idx  = held_count_q;
		emit         = 1'b0;
		job.bytes    = {b, held_q[2], held_q[1], held_q[0]};
		job.last_idx = 2'd0;
		job.marker   = 1'b0;
		job.last     = feed_item.last_byte;

		if (consumed) begin
			if (complete) begin
				if (point_ok(exp_len_q, point_shift)) begin
					emit = 1'b1;
					for (int i = 0; i < 3; i++) begin
						job.bytes[i] = (2'(i) == held_count_q) ? b : held_q[i];
					end
					job.last_idx = 2'(exp_len_q - 3'd1);
				end
				exp_len_n    = LEN_NONE;
				held_count_n = 2'd0;
				point_n      = '0;
			end else begin
				held_wr      = 1'b1;
				held_count_n = held_count_q + 2'd1;
				point_n      = point_shift;
			end
		end else begin
			// A broken sequence is dropped and the byte starts afresh.
			exp_len_n    = LEN_NONE;
			held_count_n = 2'd0;
			point_n      = '0;
			job.bytes[0] = b;
			if (b == 8'h00) begin
				emit = 1'b0;
			end else if (!b[7]) begin
				emit = 1'b1;
			end else if (b[7:5] == 3'b110) begin
				exp_len_n    = LEN_TWO;
				held_count_n = 2'd1;
				held_wr      = 1'b1;
				held_wr_idx  = 2'd0;
				point_n      = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				exp_len_n    = LEN_THREE;
				held_count_n = 2'd1;
				held_wr      = 1'b1;
				held_wr_idx  = 2'd0;
				point_n      = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				exp_len_n    = LEN_FOUR;
				held_count_n = 2'd1;
				held_wr      = 1'b1;
				held_wr_idx  = 2'd0;
				point_n      = {18'd0, b[2:0]};
			end
		end

		// End of string drops any pending sequence and may need a marker.
		if (feed_item.last_byte) begin
			exp_len_n    = LEN_NONE;
			held_count_n = 2'd0;
			point_n      = '0;
			if (!emit) begin
				emit         = 1'b1;
				job.marker   = 1'b1;
				job.last_idx = 2'd0;
			end
		end
	end

	assign job_push.push = accept && emit;
	assign job_push.job  = job;

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q    <= LEN_NONE;
			held_count_q <= 2'd0;
			point_q      <= '0;
		end else if (accept) begin
			exp_len_q    <= exp_len_n;
			held_count_q <= held_count_n;
			point_q      <= point_n;
		end
	end

	// Held bytes of the pending sequence.
	always_ff @(posedge clk) begin
		if (accept && held_wr) begin
			held_q[held_wr_idx] <= b;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/usan_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// usan_queue: job queue between front and back end
// A small first-in first-out store of job records in flip-flops.
// ---------------------------------------------------------------------------
module usan_queue #(
	parameter int QUEUE_DEPTH = usan_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  usan_pkg::usan_push_t  job_push,
	input  wire                   pop,
	output logic                  full,
	output usan_pkg::usan_head_t  job_head
);
	import usan_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	usan_job_t          jobs_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full           = (count_q == CNT_W'(QUEUE_DEPTH));
	assign job_head.ready = (count_q != '0);
	assign job_head.job   = jobs_q[rd_ptr_q];
	assign do_pop         = pop && job_head.ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (job_push.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (job_push.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!job_push.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (job_push.push) begin
			jobs_q[wr_ptr_q] <= job_push.job;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/usan_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// usan_back: result serializer
// Walks the head job one result per cycle, while the output is not stalled, into a registered output.
// ---------------------------------------------------------------------------
module usan_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  usan_pkg::usan_head_t  job_head,
	output logic                  pop,
	output logic                  result_valid,
	input  wire                   result_stall,
	output usan_pkg::usan_out_t   result_item
);
	import usan_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	usan_out_t  item_q;
	logic       load;
	logic       issue;
	logic       at_end;

	assign load   = !valid_q || !result_stall;
	assign issue  = load && job_head.ready;
	assign at_end = (idx_q == job_head.job.last_idx);
	assign pop    = issue && at_end;

	assign result_valid = valid_q;
	assign result_item  = item_q;

	// Output register control and position within the job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (issue) begin
			valid_q <= 1'b1;
			idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (issue) begin
			item_q.out_byte   <= job_head.job.marker ? 8'h00 : job_head.job.bytes[idx_q];
			item_q.byte_valid <= !job_head.job.marker;
			item_q.run_last   <= at_end;
			item_q.string_end <= at_end && job_head.job.last;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/utf8_stream_sanitizer_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utf8_stream_sanitizer_core: UTF-8 stream sanitizer
// Passes on only well-formed UTF-8 from a byte stream.
// ---------------------------------------------------------------------------
// The block takes one byte per cycle and gives one result per cycle, unless
// the queue is full or result_stall holds the output. Zero bytes and stray
// bytes are dropped, ASCII passes through, and a multi-byte sequence comes
// out whole, one byte per cycle while not stalled, only once its last
// continuation byte shows the code point is legal. A byte that ends the
// string and yields no byte gives one end marker. The first result of a
// byte passes through the job queue and then the output register. A byte
// that completes a sequence yields up to four results and so holds the
// output side while they go out; the job queue (QUEUE_DEPTH entries) absorbs
// that while the input keeps taking bytes, and the input stalls only when the queue is full.
module utf8_stream_sanitizer_core #(
	parameter int QUEUE_DEPTH = usan_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  feed_valid,
	output logic                 feed_stall,
	input  usan_pkg::usan_in_t   feed_item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output usan_pkg::usan_out_t  result_item
);
	import usan_pkg::*;

	usan_push_t push;
	usan_head_t head;
	logic       queue_full;
	logic       pop;

	// Front end: classification and sequence tracking.
	usan_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (feed_valid),
		.feed_item  (feed_item),
		.queue_full (queue_full),
		.feed_stall (feed_stall),
		.job_push   (push)
	);

	// Job queue.
	usan_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_push (push),
		.pop      (pop),
		.full     (queue_full),
		.job_head (head)
	);

	// Back end: result serialization.
	usan_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_head     (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule
`default_nettype wire

// ===== test/usan_stream_checker.sv =====
// ---------------------------------------------------------------------------
// usan_stream_checker: result checker for the UTF-8 stream sanitizer
// Watches both channels of the block. Every accepted input transfer is run
// through a behavioral copy of the sanitizer, which queues the bytes and end
// markers it should give. Every accepted result transfer is compared with
// the oldest queued one. Mismatches are counted and handed to the testbench.
// ---------------------------------------------------------------------------
module usan_stream_checker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  feed_valid,
	input  wire                  feed_stall,
	input  usan_pkg::usan_in_t   feed_item,
	input  wire                  result_valid,
	input  wire                  result_stall,
	input  usan_pkg::usan_out_t  result_item,
	output int                   fail_count,
	output int                   backlog
);
	import usan_pkg::*;

	// Decoder state: the pending sequence and the code point built so far.
	logic [7:0]  seq_bytes [3];
	logic [2:0]  seq_len;
	logic [1:0]  seq_held;
	logic [20:0] code_acc;

	// Results still owed by the block, oldest first.
	usan_out_t sanitized_q [$];

	// True when a decoded code point is the shortest form, in range and not a surrogate.
	function automatic logic code_legal(input logic [2:0] len, input logic [20:0] cp);
		logic [20:0] lo;
		logic [20:0] hi;
		logic        surrogate;
		lo = 21'h1;
		hi = 21'h0;
		surrogate = (cp >= 21'hD800) && (cp <= 21'hDFFF);
		case (len)
			LEN_TWO: begin
				lo = 21'h80;
				hi = 21'h7FF;
			end
			LEN_THREE: begin
				lo = 21'h800;
				hi = 21'hFFFF;
			end
			LEN_FOUR: begin
				lo = 21'h10000;
				hi = 21'h10FFFF;
			end
			default: begin
				lo = 21'h1;
				hi = 21'h0;
			end
		endcase
		return (cp >= lo) && (cp <= hi) && !surrogate;
	endfunction

	// A plain byte result; the flags are set once the batch is complete.
	function automatic usan_out_t byte_result(input logic [7:0] b);
		usan_out_t r;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		r.run_last = 1'b0;
		r.string_end = 1'b0;
		return r;
	endfunction

	task automatic drop_pending();
		seq_len = LEN_NONE;
		seq_held = 2'd0;
		code_acc = '0;
	endtask

	// Work out the results of one input byte and queue them.
	task automatic sanitize_byte(input usan_in_t item);
		usan_out_t  batch [$];
		usan_out_t  marker;
		logic [7:0] b;
		logic       taken;
		b = item.data_byte;
		taken = 1'b0;

		// A continuation extends the pending sequence; anything else breaks it.
		if (seq_len != LEN_NONE) begin
			if (b[7:6] == 2'b10) begin
				taken = 1'b1;
				code_acc = {code_acc[14:0], b[5:0]};
				if (int'(seq_held) + 1 >= int'(seq_len)) begin
					if (code_legal(seq_len, code_acc)) begin
						for (int k = 0; k < int'(seq_held); k++)
							batch = {batch, byte_result(seq_bytes[k])};
						batch = {batch, byte_result(b)};
					end
					drop_pending();
				end else begin
					seq_bytes[seq_held] = b;
					seq_held = seq_held + 2'd1;
				end
			end else begin
				drop_pending();
			end
		end

		// A byte not taken by a sequence is looked at on its own.
		if (!taken) begin
			if (b == 8'h00) begin
				// Zero bytes never pass.
			end else if (!b[7]) begin
				batch = {batch, byte_result(b)};
			end else if (b[7:5] == 3'b110) begin
				seq_len = LEN_TWO;
				code_acc = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				seq_len = LEN_THREE;
				code_acc = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				seq_len = LEN_FOUR;
				code_acc = {18'd0, b[2:0]};
			end
			if (seq_len != LEN_NONE) begin
				seq_bytes[0] = b;
				seq_held = 2'd1;
			end
		end

		// The end of the string drops any pending sequence and never goes silent.
		if (item.last_byte) begin
			drop_pending();
			if (batch.size() == 0) begin
				marker = '0;
				batch = {batch, marker};
			end
		end
		if (batch.size() > 0) begin
			batch[batch.size() - 1].run_last = 1'b1;
			batch[batch.size() - 1].string_end = item.last_byte;
		end
		sanitized_q = {sanitized_q, batch};
	endtask

	// Compare each result transfer, then predict from each input transfer.
	always @(posedge clk or negedge arst_n) begin : watch
		usan_out_t want;
		if (!arst_n) begin
			sanitized_q.delete();
			drop_pending();
			foreach (seq_bytes[i])
				seq_bytes[i] = '0;
			backlog = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (sanitized_q.size() == 0) begin
					$display("%0t: unexpected result out_byte=%h byte_valid=%b run_last=%b string_end=%b",
						$time, result_item.out_byte, result_item.byte_valid,
						result_item.run_last, result_item.string_end);
					fail_count++;
				end else begin
					want = sanitized_q.pop_front();
					if (result_item !== want) begin
						$display("%0t: mismatch expected %h/%b/%b/%b actual %h/%b/%b/%b",
							$time, want.out_byte, want.byte_valid, want.run_last,
							want.string_end, result_item.out_byte, result_item.byte_valid,
							result_item.run_last, result_item.string_end);
						fail_count++;
					end
				end
			end
			if (feed_valid && !feed_stall)
				sanitize_byte(feed_item);
			backlog = sanitized_q.size();
		end
	end

endmodule

// ===== test/tb_utf8_stream_sanitizer_core.sv =====
// ---------------------------------------------------------------------------
// tb_utf8_stream_sanitizer_core: testbench of the UTF-8 stream sanitizer
// Feeds a directed set of byte strings and then random strings made mostly
// of well-formed sequences, with illegal code points, broken sequences and
// noise mixed in. Both channels idle at random. The checker beside the
// block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_utf8_stream_sanitizer_core;
	import usan_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_BYTES = 300;
	localparam int HOLD_CYCLES = 80;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;
	typedef enum int {U_ASCII, U_GOOD_SEQ, U_BAD_POINT, U_BROKEN, U_NOISE} unit_kind_t;

	logic      clk;
	logic      arst_n;
	logic      feed_valid;
	logic      feed_stall;
	usan_in_t  feed_item;
	logic      result_valid;
	logic      result_stall;
	usan_out_t result_item;
	logic      hold_req;
	int        mismatches;
	int        backlog;
	int        burst_left;
	int        quiet_cycles;
	logic [7:0] unit_bytes [$];
	logic       unit_ends;

	utf8_stream_sanitizer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed_valid),
		.feed_stall   (feed_stall),
		.feed_item    (feed_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	usan_stream_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed_valid),
		.feed_stall   (feed_stall),
		.feed_item    (feed_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.fail_count   (mismatches),
		.backlog      (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one byte at a falling edge and hold it until the transfer.
	task automatic send_item(input logic [7:0] b, input logic l);
		feed_item.data_byte = b;
		feed_item.last_byte = l;
		feed_valid = 1'b1;
		@(posedge clk);
		while (feed_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_feed(input int cycles);
		feed_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Send a byte as part of the current burst; a gap may follow the burst.
	task automatic offer(input logic [7:0] b, input logic l);
		int gap;
		send_item(b, l);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0)
				pause_feed(gap);
			burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 24);
		end
	endtask

	// A code point for a sequence length: legal, or overlong, surrogate or too large.
	function automatic logic [20:0] pick_point(input int len, input bit bad);
		int lo;
		int hi;
		bit coin;
		coin = $urandom_range(0, 1);
		if (!bad) begin
			case (len)
				2: begin lo = 'h80; hi = 'h7FF; end
				3: begin lo = coin ? 'h800 : 'hE000; hi = coin ? 'hD7FF : 'hFFFF; end
				default: begin lo = 'h10000; hi = 'h10FFFF; end
			endcase
		end else begin
			case (len)
				2: begin lo = 'h0; hi = 'h7F; end
				3: begin lo = coin ? 'h0 : 'hD800; hi = coin ? 'h7FF : 'hDFFF; end
				default: begin lo = coin ? 'h0 : 'h110000; hi = coin ? 'hFFFF : 'h1FFFFF; end
			endcase
		end
		case ($urandom_range(0, 7))
			0: return 21'(lo);
			1: return 21'(hi);
			default: return 21'($urandom_range(lo, hi));
		endcase
	endfunction

	// Encode a code point in the byte pattern of the given length.
	task automatic put_sequence(input int len, input logic [20:0] cp);
		case (len)
			2: begin
				unit_bytes = {unit_bytes, {3'b110, cp[10:6]}};
				unit_bytes = {unit_bytes, {2'b10, cp[5:0]}};
			end
			3: begin
				unit_bytes = {unit_bytes, {4'b1110, cp[15:12]}};
				unit_bytes = {unit_bytes, {2'b10, cp[11:6]}};
				unit_bytes = {unit_bytes, {2'b10, cp[5:0]}};
			end
			default: begin
				unit_bytes = {unit_bytes, {5'b11110, cp[20:18]}};
				unit_bytes = {unit_bytes, {2'b10, cp[17:12]}};
				unit_bytes = {unit_bytes, {2'b10, cp[11:6]}};
				unit_bytes = {unit_bytes, {2'b10, cp[5:0]}};
			end
		endcase
	endtask

	// Build one random unit of bytes; weight is zero for plain noise.
	task automatic make_unit(output int weight);
		unit_kind_t kind;
		int         pick;
		int         len;
		int         keep;
		int         v;
		unit_bytes.delete();
		unit_ends = ($urandom_range(0, 99) < 8);
		pick = $urandom_range(0, 99);
		len = $urandom_range(2, 4);
		if (pick < 35)
			kind = U_ASCII;
		else if (pick < 75)
			kind = U_GOOD_SEQ;
		else if (pick < 85)
			kind = U_BAD_POINT;
		else if (pick < 95)
			kind = U_BROKEN;
		else
			kind = U_NOISE;
		case (kind)
			U_ASCII: unit_bytes = {unit_bytes, 8'($urandom_range(1, 127))};
			U_GOOD_SEQ: put_sequence(len, pick_point(len, 1'b0));
			U_BAD_POINT: put_sequence(len, pick_point(len, 1'b1));
			U_BROKEN: begin
				// Cut the sequence short, then break it unless the string ends there.
				put_sequence(len, pick_point(len, 1'b0));
				keep = $urandom_range(1, len - 1);
				while (unit_bytes.size() > keep)
					void'(unit_bytes.pop_back());
				if (!unit_ends) begin
					v = $urandom_range(0, 191);
					unit_bytes = {unit_bytes, 8'((v < 128) ? v : v + 64)};
				end
			end
			default: unit_bytes = {unit_bytes, 8'($urandom_range(0, 255))};
		endcase
		weight = (kind == U_NOISE) ? 0 : unit_bytes.size();
	endtask

	// Receiver: changing stall patterns, and one long hold-off on request.
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		int       beat;
		bit       hold_done;
		result_stall = 1'b0;
		mode = RX_FREE;
		mode_left = 0;
		beat = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 60);
				end
				mode_left--;
				beat++;
				case (mode)
					RX_FREE: result_stall = 1'b0;
					RX_LIGHT: result_stall = ($urandom_range(0, 99) < 30);
					RX_HEAVY: result_stall = ($urandom_range(0, 99) < 70);
					default: result_stall = (beat % 3 == 0);
				endcase
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed_valid && !feed_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int sent;
		int w;
		bit held_off;
		bit drained;
		arst_n = 1'b0;
		feed_valid = 1'b0;
		feed_item = '0;
		hold_req = 1'b0;
		burst_left = 0;
		sent = 0;
		held_off = 1'b0;
		drained = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero byte, an ASCII byte, and the largest ASCII byte, which ends a string.
		offer(8'h00, 1'b0);
		offer(8'h41, 1'b0);
		offer(8'h7F, 1'b1);
		// A legal two byte sequence and an overlong one, then a legal three byte sequence and a surrogate.
		offer(8'hC2, 1'b0);
		offer(8'hA9, 1'b0);
		offer(8'hC0, 1'b0);
		offer(8'h80, 1'b0);
		offer(8'hE2, 1'b0);
		offer(8'h82, 1'b0);
		offer(8'hAC, 1'b0);
		offer(8'hED, 1'b0);
		offer(8'hA0, 1'b0);
		offer(8'h80, 1'b0);
		// Largest legal code point, ending the string with four results.
		offer(8'hF4, 1'b0);
		offer(8'h8F, 1'b0);
		offer(8'hBF, 1'b0);
		offer(8'hBF, 1'b1);
		// Bytes that can never lead, with nothing pending.
		offer(8'hFF, 1'b0);
		offer(8'h80, 1'b0);
		// A sequence broken by an ASCII byte, which still passes.
		offer(8'hE2, 1'b0);
		offer(8'h41, 1'b0);
		// The string ends inside a sequence, then on a zero byte.
		offer(8'hE2, 1'b0);
		offer(8'h82, 1'b1);
		offer(8'h00, 1'b1);

		// Random strings.
		while (sent < RANDOM_BYTES) begin
			if (!held_off && sent >= 120) begin
				// The receiver holds off while bytes keep coming, so the block fills up.
				held_off = 1'b1;
				hold_req = 1'b1;
				repeat (40) send_item(8'($urandom_range(1, 127)), 1'b0);
			end
			if (!drained && sent >= 240) begin
				drained = 1'b1;
				pause_feed(1);
				while (backlog != 0)
					@(negedge clk);
			end
			make_unit(w);
			foreach (unit_bytes[i])
				offer(unit_bytes[i], unit_ends && (i == unit_bytes.size() - 1));
			sent += w;
		end

		// Let every owed result arrive, then watch for stray ones.
		pause_feed(1);
		while (backlog != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/usan_pkg.sv
hdl/usan_front.sv
hdl/usan_queue.sv
hdl/usan_back.sv
hdl/utf8_stream_sanitizer_core.sv
test/usan_stream_checker.sv
test/tb_utf8_stream_sanitizer_core.sv
